FILE: design/fir16_pkg.sv
package fir16_pkg;

   // accumulator wraps modulo 2^ACC_BITS
   localparam int ACC_BITS   = 64;
   localparam int BASE_FRAC  = 16;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_READ,
      CTL_DRAIN,
      CTL_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic accept;  // take the request: write the store, clear the sum
      logic read;    // issue one tap read and advance the tap count
      logic emit;    // load the rounded sum into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic last_read;
      logic out_free;
   } dp_status_type;

   // Q1.15 low-pass weights, rescaled to coef_bits (round half up when narrowing)
   function automatic logic signed [31:0] coef_value(input int k, input int coef_bits);
      int base;
      int s;
      base = 0;
      s    = 0;
      case (k)
         0:       base = -111;
         1:       base = -128;
         2:       base = -85;
         3:       base = 254;
         4:       base = 1108;
         5:       base = 2481;
         6:       base = 4070;
         7:       base = 5356;
         8:       base = 5851;
         9:       base = 5356;
         10:      base = 4070;
         11:      base = 2481;
         12:      base = 1108;
         13:      base = 254;
         14:      base = -85;
         15:      base = -128;
         default: base = 0;
      endcase
      if (coef_bits >= BASE_FRAC) begin
         return base <<< (coef_bits - BASE_FRAC);
      end
      s = BASE_FRAC - coef_bits;
      return (base + (1 <<< (s - 1))) >>> s;
   endfunction

endpackage

FILE: design/fir16_ctrl.sv
module fir16_ctrl import fir16_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          drain_ff, drain_in;
   logic          ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      drain_in = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_READ;
         end
         CTL_READ: begin
            if (status.last_read) state_in = CTL_DRAIN;
         end
         CTL_DRAIN: begin
            // wait here until the multiply and accumulate stages have emptied
            drain_in = ~drain_ff;
            if (drain_ff) state_in = CTL_FINISH;
         end
         CTL_FINISH: begin
            if (status.out_free) state_in = req_valid ? CTL_READ : CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ready      = 1'b0;
      cmd.read   = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         CTL_IDLE:   ready = 1'b1;
         CTL_READ:   cmd.read = 1'b1;
         CTL_DRAIN:  ;
         CTL_FINISH: begin
            ready    = status.out_free;
            cmd.emit = status.out_free;
         end
         default:    ;
      endcase
      cmd.accept = ready & req_valid;
      req_stall  = ~ready;
   end

endmodule

FILE: design/fir16_dp.sv
module fir16_dp import fir16_pkg::*; #(
   parameter int TAPS        = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   localparam int PTR_BITS  = $clog2(TAPS);
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(TAPS - 1);
   localparam logic signed [ACC_BITS-1:0] ROUND  = ACC_BITS'(1) <<< (COEF_BITS - 2);
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

   logic signed [SAMPLE_BITS-1:0] store_mem [TAPS];
   logic [TAPS-1:0]               store_valid_ff, store_valid_in;
   logic [PTR_BITS-1:0]           wp_ff, wp_in;
   logic [PTR_BITS-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]           k_ff, k_in;

   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic signed [COEF_BITS-1:0]   coef_ff, coef_in;
   logic                          s1_ff, s2_ff;
   logic signed [SAMPLE_BITS-1:0] tap_sample;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]    rounded, shifted;
   logic signed [SAMPLE_BITS-1:0] result;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff;

   // sample store: one write per request, one tap read per cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) store_mem[wp_ff] <= req_sample;
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= store_mem[rd_ptr_ff];
      rd_valid_ff <= store_valid_ff[rd_ptr_ff];
   end

   always_comb begin
      store_valid_in = store_valid_ff;
      wp_in          = wp_ff;
      rd_ptr_in      = rd_ptr_ff;
      k_in           = k_ff;
      if (cmd.accept) begin
         store_valid_in[wp_ff] = 1'b1;
         wp_in     = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
         rd_ptr_in = wp_ff;
         k_in      = '0;
      end else if (cmd.read) begin
         // step back one sample, wrapping
         rd_ptr_in = (rd_ptr_ff == '0) ? LAST_PTR : rd_ptr_ff - 1'b1;
         k_in      = k_ff + 1'b1;
      end
   end

   assign coef_in    = COEF_BITS'(coef_value(int'(k_ff), COEF_BITS));
   assign tap_sample = rd_valid_ff ? rd_data_ff : '0;
   assign prod_in    = tap_sample * coef_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.accept) begin
         acc_in = '0;
      end else if (s2_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= '0;
         wp_ff          <= '0;
         rd_ptr_ff      <= '0;
         k_ff           <= '0;
         s1_ff          <= 1'b0;
         s2_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         store_valid_ff <= store_valid_in;
         wp_ff          <= wp_in;
         rd_ptr_ff      <= rd_ptr_in;
         k_ff           <= k_in;
         s1_ff          <= cmd.read;
         s2_ff          <= s1_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.emit) rsp_filtered_ff <= result;
   end

   // round half up, drop the fraction, clamp
   assign rounded = acc_ff + ROUND;
   assign shifted = rounded >>> (COEF_BITS - 1);

   always_comb begin
      if (shifted > SAT_HI) begin
         result = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result = shifted[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_valid_in     = cmd.emit | (rsp_valid_ff & rsp_stall);
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign status.last_read = (k_ff == LAST_PTR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered     = rsp_filtered_ff;

endmodule

FILE: design/fir_filter_16_tap.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_sample   (signed SAMPLE_BITS)
// rsp_      out        rsp_valid/rsp_stall  rsp_filtered (signed SAMPLE_BITS)
//
// A request passes through the states READ, DRAIN and FINISH: a single shared
// multiply-accumulate handles one tap per cycle in READ, DRAIN lets the multiply
// and accumulate stages empty, and FINISH rounds and loads the output register.
// Reset is synchronous and clears the pointers and the store's valid bits, so
// unwritten taps read as zero. A new request is taken while a result still
// waits in the output register; rsp_stall holds the result until taken.
module fir_filter_16_tap import fir16_pkg::*; #(
   parameter int TAPS        = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   dp_cmd_type    cmd;
   dp_status_type status;

   fir16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fir16_dp #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

`ifndef SYNTHESIS
   // a result can never be ready the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !cmd.emit)
      else $error("result emitted right after request");

   assert property (@(posedge clock) disable iff (reset)
      !(cmd.read && (cmd.emit || cmd.accept)))
      else $error("tap read overlaps request or emit");

   // never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.emit)
      else $error("output register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.read && status.last_read) |=> !cmd.read)
      else $error("tap read past last tap");
`endif

endmodule
